/* rtl/hsvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Constants and types shared by the hsv to rgb converter pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int unsigned HUE_W   = 9;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned LED_W   = 6;
  localparam int unsigned CHAN_W  = 8;

  // chroma, offset and per-channel sums are on a 0..10000 scale
  localparam int unsigned SCALE_W = 14;
  // ramp factor 0..60
  localparam int unsigned RAMP_W  = 6;
  // chroma times ramp factor, up to 600000
  localparam int unsigned CK_W    = 20;
  // sum times 255, up to 2550000
  localparam int unsigned T_W     = 22;

  localparam logic [PCT_W-1:0]   FULL_PCT   = 7'd100;
  localparam logic [HUE_W-1:0]   TURN       = 9'd360;
  localparam logic [HUE_W-1:0]   SEXT_DEG   = 9'd60;
  localparam logic [HUE_W-1:0]   SEXT_DEG2  = 9'd120;
  localparam logic [HUE_W-1:0]   SEXT_DEG3  = 9'd180;
  localparam logic [HUE_W-1:0]   SEXT_DEG4  = 9'd240;
  localparam logic [HUE_W-1:0]   SEXT_DEG5  = 9'd300;

  // floor(n / 60) for n <= 600000 as (n * DIV60_MUL) >> DIV60_SHIFT
  localparam int unsigned        DIV60_SHIFT = 26;
  localparam logic [20:0]        DIV60_MUL   = 21'd1118482;
  localparam int unsigned        DIV60_PW    = CK_W + 21;

  // floor(n / 10000) for n <= 2550000 as (n * DIV10K_MUL) >> DIV10K_SHIFT
  localparam int unsigned        DIV10K_SHIFT = 35;
  localparam logic [21:0]        DIV10K_MUL   = 22'd3435974;
  localparam int unsigned        DIV10K_PW    = T_W + 22;

  typedef enum logic [2:0] {
    SEXT_RED_YEL = 3'd0,
    SEXT_YEL_GRN = 3'd1,
    SEXT_GRN_CYN = 3'd2,
    SEXT_CYN_BLU = 3'd3,
    SEXT_BLU_MAG = 3'd4,
    SEXT_MAG_RED = 3'd5
  } sextant_t;

  typedef struct packed {
    logic en;
  } pipe_ctl_t;

endpackage

/* rtl/hsv_to_rgb_converter_top.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV to 8-bit RGB conversion for one LED color per beat.
// ----------------------------------------------------------------------------
// Six-stage pipeline: one beat is accepted every cycle unless the output beat
// is stalled. The whole pipeline advances together and holds while the output
// beat is stalled; in_stall is high exactly then. Hue values of 360 and up
// wrap by 360, percents above 100 clamp to 100, and led_index travels
// unchanged to led_out. Each multiplier (chroma, ramp, reciprocal divide by 60
// and by 10000) sits in a stage of its own.
module hsv_to_rgb_converter_top
  import hsvrgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [HUE_W-1:0]  in_hue,
  input  logic [PCT_W-1:0]  in_saturation,
  input  logic [PCT_W-1:0]  in_brightness,
  input  logic [LED_W-1:0]  in_led_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue,
  output logic [LED_W-1:0]  out_led_out
);

  pipe_ctl_t ctl;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, out_vld_r;

  // stage 1: wrap and clamp
  logic [HUE_W-1:0]   s1_hue_nxt, s1_hue_r;
  logic [PCT_W-1:0]   s1_sat_nxt, s1_sat_r;
  logic [PCT_W-1:0]   s1_val_nxt, s1_val_r;
  logic [LED_W-1:0]   s1_led_r;

  // stage 2: chroma, value*100, sextant, ramp factor
  logic [SCALE_W-1:0] s2_c_r, s2_vh_r;
  sextant_t           s2_sext_nxt, s2_sext_r;
  logic [HUE_W-1:0]   s2_hm;
  logic [RAMP_W-1:0]  s2_k_nxt, s2_k_r;
  logic [LED_W-1:0]   s2_led_r;

  // stage 3: chroma times ramp, offset
  logic [CK_W-1:0]    s3_ck_r;
  logic [SCALE_W-1:0] s3_c_r, s3_m_r;
  sextant_t           s3_sext_r;
  logic [LED_W-1:0]   s3_led_r;

  // stage 4: ramp divided by 60
  logic [DIV60_PW-1:0] s4_prod;
  logic [SCALE_W-1:0]  s4_x_r, s4_c_r, s4_m_r;
  sextant_t            s4_sext_r;
  logic [LED_W-1:0]    s4_led_r;

  // stages 5 and 6 live in the channel scalers
  logic [SCALE_W-1:0] r_part, g_part, b_part;
  logic [LED_W-1:0]   s5_led_r, out_led_r;

  assign ctl.en   = !(out_vld_r && out_stall);
  assign in_stall = !ctl.en;

  // stage 1 logic
  always_comb begin
    s1_hue_nxt = (in_hue >= TURN) ? (in_hue - TURN) : in_hue;
    s1_sat_nxt = (in_saturation > FULL_PCT) ? FULL_PCT : in_saturation;
    s1_val_nxt = (in_brightness > FULL_PCT) ? FULL_PCT : in_brightness;
  end

  // stage 2 logic
  always_comb begin
    if (s1_hue_r < SEXT_DEG)       s2_sext_nxt = SEXT_RED_YEL;
    else if (s1_hue_r < SEXT_DEG2) s2_sext_nxt = SEXT_YEL_GRN;
    else if (s1_hue_r < SEXT_DEG3) s2_sext_nxt = SEXT_GRN_CYN;
    else if (s1_hue_r < SEXT_DEG4) s2_sext_nxt = SEXT_CYN_BLU;
    else if (s1_hue_r < SEXT_DEG5) s2_sext_nxt = SEXT_BLU_MAG;
    else                           s2_sext_nxt = SEXT_MAG_RED;

    if (s1_hue_r < SEXT_DEG2)      s2_hm = s1_hue_r;
    else if (s1_hue_r < SEXT_DEG4) s2_hm = s1_hue_r - SEXT_DEG2;
    else                           s2_hm = s1_hue_r - SEXT_DEG4;

    // triangle ramp 60 - |hm - 60|
    if (s2_hm <= SEXT_DEG) s2_k_nxt = s2_hm[RAMP_W-1:0];
    else                   s2_k_nxt = 6'(SEXT_DEG2 - s2_hm);
  end

  assign s4_prod = {{(DIV60_PW-CK_W){1'b0}}, s3_ck_r} * {{(DIV60_PW-21){1'b0}}, DIV60_MUL};

  // stage 5 part select
  always_comb begin
    r_part = '0;
    g_part = '0;
    b_part = '0;
    case (s4_sext_r)
      SEXT_RED_YEL: begin r_part = s4_c_r; g_part = s4_x_r; end
      SEXT_YEL_GRN: begin r_part = s4_x_r; g_part = s4_c_r; end
      SEXT_GRN_CYN: begin g_part = s4_c_r; b_part = s4_x_r; end
      SEXT_CYN_BLU: begin g_part = s4_x_r; b_part = s4_c_r; end
      SEXT_BLU_MAG: begin r_part = s4_x_r; b_part = s4_c_r; end
      default:      begin r_part = s4_c_r; b_part = s4_x_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (ctl.en) begin
      s1_vld_r  <= in_valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      out_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s1_hue_r  <= s1_hue_nxt;
      s1_sat_r  <= s1_sat_nxt;
      s1_val_r  <= s1_val_nxt;
      s1_led_r  <= in_led_index;

      s2_c_r    <= SCALE_W'(s1_sat_r * s1_val_r);
      s2_vh_r   <= SCALE_W'(s1_val_r * FULL_PCT);
      s2_sext_r <= s2_sext_nxt;
      s2_k_r    <= s2_k_nxt;
      s2_led_r  <= s1_led_r;

      s3_ck_r   <= CK_W'(s2_c_r * s2_k_r);
      s3_c_r    <= s2_c_r;
      s3_m_r    <= s2_vh_r - s2_c_r;
      s3_sext_r <= s2_sext_r;
      s3_led_r  <= s2_led_r;

      s4_x_r    <= s4_prod[DIV60_SHIFT +: SCALE_W];
      s4_c_r    <= s3_c_r;
      s4_m_r    <= s3_m_r;
      s4_sext_r <= s3_sext_r;
      s4_led_r  <= s3_led_r;

      s5_led_r  <= s4_led_r;
      out_led_r <= s5_led_r;
    end
  end

  hsvrgb_chan_scale u_red (
    .clk    (clk),
    .ctl    (ctl),
    .part   (r_part),
    .offset (s4_m_r),
    .chan   (out_red)
  );

  hsvrgb_chan_scale u_green (
    .clk    (clk),
    .ctl    (ctl),
    .part   (g_part),
    .offset (s4_m_r),
    .chan   (out_green)
  );

  hsvrgb_chan_scale u_blue (
    .clk    (clk),
    .ctl    (ctl),
    .part   (b_part),
    .offset (s4_m_r),
    .chan   (out_blue)
  );

  assign out_valid   = out_vld_r;
  assign out_led_out = out_led_r;

endmodule

/* rtl/hsvrgb_chan_scale.sv */
// ----------------------------------------------------------------------------
// hsvrgb_chan_scale
// Two-stage scaler for one color channel: (part + offset) * 255 / 10000.
// ----------------------------------------------------------------------------
module hsvrgb_chan_scale
  import hsvrgb_pkg::*;
(
  input  logic               clk,
  input  pipe_ctl_t          ctl,
  input  logic [SCALE_W-1:0] part,
  input  logic [SCALE_W-1:0] offset,
  output logic [CHAN_W-1:0]  chan
);

  logic [SCALE_W-1:0]   sum;
  logic [T_W-1:0]       t_nxt;
  logic [T_W-1:0]       t_r;
  logic [DIV10K_PW-1:0] prod;
  logic [CHAN_W-1:0]    chan_r;

  // sum never exceeds 10000, so it stays in 14 bits
  assign sum   = part + offset;
  assign t_nxt = {sum, 8'd0} - {8'd0, sum};
  assign prod  = {{(DIV10K_PW-T_W){1'b0}}, t_r} * {{(DIV10K_PW-22){1'b0}}, DIV10K_MUL};

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      t_r    <= t_nxt;
      chan_r <= prod[DIV10K_SHIFT +: CHAN_W];
    end
  end

  assign chan = chan_r;

endmodule

/* rtl/hsvrgb_checker.sv */
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks for the hsv to rgb converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsvrgb_checker
  import hsvrgb_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [LED_W-1:0]  in_led_index,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAN_W-1:0] out_red,
  input logic [CHAN_W-1:0] out_green,
  input logic [CHAN_W-1:0] out_blue,
  input logic [LED_W-1:0]  out_led_out
);

  // stalled beat stays valid
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  // stalled beat keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_led_out))
    else $error("output payload changed while stalled");

  // input only waits on a stalled output beat
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // a beat accepted with no stall behind it reaches the output with its led index
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall
      ##1 !in_stall ##1 !in_stall
    |=> out_valid && out_led_out == $past(in_led_index, 6))
    else $error("beat lost or led index corrupted in pipeline");

endmodule

bind hsv_to_rgb_converter_top hsvrgb_checker u_hsvrgb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_led_index (in_led_index),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_red      (out_red),
  .out_green    (out_green),
  .out_blue     (out_blue),
  .out_led_out  (out_led_out)
);
